### hdl/rational_arithmetic_unit_assert.svh
// Assertion macros shared by the rational arithmetic unit RTL.
`ifndef RATIONAL_ARITHMETIC_UNIT_ASSERT_SVH
`define RATIONAL_ARITHMETIC_UNIT_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define RAU_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("rational unit assertion failed");

// Next-cycle implication, checked out of reset.
`define RAU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("rational unit assertion failed");

`endif

### hdl/rau_pkg.sv
// Types, codes and constants of the rational arithmetic unit.
`default_nettype none
package rau_pkg;

	localparam int RAU_WIDTH = 32;
	localparam int RAU_EFF_W = (RAU_WIDTH < 32) ? RAU_WIDTH : 32;
	localparam logic [63:0] RAU_HALF = 64'd1 << (RAU_EFF_W - 1);

	typedef enum logic [2:0] {
		OP_ADD  = 3'd0,
		OP_SUB  = 3'd1,
		OP_MUL  = 3'd2,
		OP_DIV  = 3'd3,
		OP_NEG  = 3'd4,
		OP_CMP  = 3'd5,
		OP_NORM = 3'd6
	} op_t;

	localparam logic [1:0] ORD_LESS    = 2'd0;
	localparam logic [1:0] ORD_EQUAL   = 2'd1;
	localparam logic [1:0] ORD_GREATER = 2'd2;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_DIVZ = 2'd1;
	localparam logic [1:0] ST_OVF  = 2'd2;

	// Magnitude of a 32-bit two's complement value; the most negative value maps to 2^31.
	function automatic logic [31:0] abs32(input logic [31:0] x);
		abs32 = x[31] ? (~x + 32'd1) : x;
	endfunction

endpackage
`default_nettype wire

### hdl/rational_arithmetic_unit.sv
// Top level of the rational arithmetic unit: sequencer, shared multiplier and result register.
`default_nettype none
// Rational arithmetic unit. Each input word carries an operation and two signed fractions
// a_num/a_den and b_num/b_den; each produces exactly one result word with the reduced
// fraction (sign on res_num, res_den positive, zero given as 0/1), a compare order and a
// status (ok, division by zero, overflow). Words are taken one at a time: in_ready is high
// only while the sequencer is idle. An item runs through the one shared 32x32 multiplier for
// the cross products and the denominator product, a combine step, and then the reduction
// unit: a binary GCD that takes one subtract or shift per cycle, followed by two restoring
// divisions by the GCD on a single subtractor. Errors and the unused operation code go
// straight to the finish, and compare skips the reduction. The finished word sits in an
// output register, and the next word can be accepted while it waits to be taken.
module rational_arithmetic_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [2:0]  operation,
	input  wire logic signed [31:0] a_num,
	input  wire logic signed [31:0] a_den,
	input  wire logic signed [31:0] b_num,
	input  wire logic signed [31:0] b_den,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic signed [31:0] res_num,
	output logic [30:0]      res_den,
	output logic [1:0]       order,
	output logic [1:0]       status
);
	import rau_pkg::*;
	`include "rational_arithmetic_unit_assert.svh"

	typedef enum logic [2:0] {S_IDLE, S_MUL, S_COMB, S_RED, S_FIN} state_t;

	state_t      state_q;
	op_t         op_q;
	logic [31:0] am_q, ad_q, bm_q, bd_q;
	logic        a_neg_q, b_neg_q, r_neg_q, use_red_q;
	logic [1:0]  cnt_q;
	logic [63:0] x_q, y_q, d_q;
	logic [31:0] fin_num_q;
	logic [30:0] fin_den_q;
	logic [1:0]  fin_ord_q, fin_st_q;

	logic        out_valid_q;
	logic [31:0] out_num_q;
	logic [30:0] out_den_q;
	logic [1:0]  out_ord_q, out_st_q;

	// Operand magnitudes and signs straight from the ports, used at acceptance.
	logic [31:0] am_in, ad_in, bm_in, bd_in;
	logic        uses_b, in_divz, in_rsvd, accept;
	op_t         op_in;

	always_comb begin
		am_in   = abs32(a_num);
		ad_in   = abs32(a_den);
		bm_in   = abs32(b_num);
		bd_in   = abs32(b_den);
		op_in   = op_t'(operation);
		in_rsvd = (operation == 3'd7);
		uses_b  = !(op_in == OP_NEG || op_in == OP_NORM);
		in_divz = (ad_in == 32'd0) || (uses_b && bd_in == 32'd0) ||
			(op_in == OP_DIV && bm_in == 32'd0);
		accept  = in_valid && in_ready;
	end

	// The shared multiplier: the step counter picks the operand pair.
	logic        one_scale;
	logic [31:0] mul_a, mul_b;
	logic [63:0] prod;

	always_comb begin
		one_scale = (op_q == OP_NEG) || (op_q == OP_NORM);
		case (cnt_q)
			2'd0: begin
				mul_a = am_q;
				mul_b = (op_q == OP_MUL) ? bm_q : (one_scale ? 32'd1 : bd_q);
			end
			2'd1: begin
				mul_a = bm_q;
				mul_b = ad_q;
			end
			default: begin
				mul_a = ad_q;
				mul_b = (op_q == OP_DIV) ? bm_q : (one_scale ? 32'd1 : bd_q);
			end
		endcase
		prod = 64'(mul_a) * 64'(mul_b);
	end

	// Combination of the cross products into a signed magnitude, and the compare order.
	logic [64:0] diff;
	logic        x_ge_y, b_neg_eff, c_neg;
	logic [63:0] c_mag;
	logic [1:0]  cmp_ord;

	always_comb begin
		diff      = {1'b0, x_q} - {1'b0, y_q};
		x_ge_y    = !diff[64];
		b_neg_eff = (op_q == OP_SUB) ? (bm_q != 32'd0 && !b_neg_q) : b_neg_q;
		c_mag     = x_q;
		c_neg     = a_neg_q;
		case (op_q) inside
			OP_ADD, OP_SUB: begin
				if (a_neg_q == b_neg_eff) begin
					c_mag = x_q + y_q;
					c_neg = a_neg_q;
				end else if (x_ge_y) begin
					c_mag = diff[63:0];
					c_neg = a_neg_q;
				end else begin
					c_mag = y_q - x_q;
					c_neg = b_neg_eff;
				end
			end
			OP_MUL, OP_DIV: c_neg = a_neg_q ^ b_neg_q;
			OP_NEG:         c_neg = !a_neg_q && am_q != 32'd0;
			default:        c_neg = a_neg_q;
		endcase
		if (a_neg_q != b_neg_q) begin
			cmp_ord = a_neg_q ? ORD_LESS : ORD_GREATER;
		end else if (x_q == y_q) begin
			cmp_ord = ORD_EQUAL;
		end else if ((!x_ge_y) != a_neg_q) begin
			cmp_ord = ORD_LESS;
		end else begin
			cmp_ord = ORD_GREATER;
		end
	end

	logic        red_start, red_done;
	logic [63:0] red_mag, red_den;

	assign red_start = (state_q == S_COMB) && (op_q != OP_CMP);

	rau_reduce u_reduce (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (red_start),
		.mag_in  (c_mag),
		.den_in  (d_q),
		.done    (red_done),
		.mag_out (red_mag),
		.den_out (red_den)
	);

	// Range check of the reduced result against the signed field width, and choice of the word to write.
	logic        f_neg, f_ovf;
	logic [63:0] f_lim;
	logic [31:0] f_num;
	logic [30:0] f_den;
	logic [1:0]  f_st;
	logic        out_free;

	always_comb begin
		f_neg = r_neg_q && red_mag != 64'd0;
		f_lim = f_neg ? RAU_HALF : (RAU_HALF - 64'd1);
		f_ovf = (red_mag > f_lim) || (red_den > (RAU_HALF - 64'd1));
		if (!use_red_q) begin
			f_num = fin_num_q;
			f_den = fin_den_q;
			f_st  = fin_st_q;
		end else if (f_ovf) begin
			f_num = 32'd0;
			f_den = 31'd1;
			f_st  = ST_OVF;
		end else begin
			f_num = f_neg ? (~red_mag[31:0] + 32'd1) : red_mag[31:0];
			f_den = red_den[30:0];
			f_st  = ST_OK;
		end
		out_free = !out_valid_q || out_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			use_red_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// A word taken while a new one is written in S_FIN is replaced there.
			if (out_valid_q && out_ready && state_q != S_FIN) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						op_q      <= op_in;
						am_q      <= am_in;
						ad_q      <= ad_in;
						bm_q      <= bm_in;
						bd_q      <= bd_in;
						a_neg_q   <= (a_num[31] ^ a_den[31]) && am_in != 32'd0;
						b_neg_q   <= (b_num[31] ^ b_den[31]) && bm_in != 32'd0;
						cnt_q     <= '0;
						use_red_q <= 1'b0;
						fin_num_q <= 32'd0;
						fin_den_q <= 31'd1;
						fin_ord_q <= ORD_LESS;
						fin_st_q  <= (!in_rsvd && in_divz) ? ST_DIVZ : ST_OK;
						if (in_rsvd || in_divz) begin
							state_q <= S_FIN;
						end else begin
							state_q <= S_MUL;
						end
					end
				end
				S_MUL: begin
					cnt_q <= cnt_q + 2'd1;
					case (cnt_q)
						2'd0:    x_q <= prod;
						2'd1:    y_q <= prod;
						default: d_q <= prod;
					endcase
					if (cnt_q == 2'd2) begin
						state_q <= S_COMB;
					end
				end
				S_COMB: begin
					r_neg_q <= c_neg;
					if (op_q == OP_CMP) begin
						fin_ord_q <= cmp_ord;
						state_q   <= S_FIN;
					end else begin
						state_q <= S_RED;
					end
				end
				S_RED: begin
					if (red_done) begin
						use_red_q <= 1'b1;
						state_q   <= S_FIN;
					end
				end
				S_FIN: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_num_q   <= f_num;
						out_den_q   <= f_den;
						out_ord_q   <= fin_ord_q;
						out_st_q    <= f_st;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign res_num   = out_num_q;
	assign res_den   = out_den_q;
	assign order     = out_ord_q;
	assign status    = out_st_q;

	`RAU_ASSERT_IMPLIES(a_err_zero, clk, arst_n, out_valid_q && out_st_q != ST_OK,
		out_num_q == 32'd0 && out_den_q == 31'd1 && out_ord_q == ORD_LESS)
	`RAU_ASSERT_IMPLIES(a_den_pos, clk, arst_n, out_valid_q, out_den_q != 31'd0)
	`RAU_ASSERT_IMPLIES(a_red_wait, clk, arst_n, red_done, state_q == S_RED)
	`RAU_ASSERT_NEXT(a_fin_write, clk, arst_n, state_q == S_FIN && out_free, out_valid_q)

endmodule
`default_nettype wire

### hdl/rau_reduce.sv
// Reduction of a fraction magnitude to lowest terms: binary GCD, then two restoring divisions.
`default_nettype none
module rau_reduce (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [63:0] mag_in,
	input  wire logic [63:0] den_in,
	output logic             done,
	output logic [63:0]      mag_out,
	output logic [63:0]      den_out
);
	import rau_pkg::*;
	`include "rational_arithmetic_unit_assert.svh"

	typedef enum logic [1:0] {R_IDLE, R_GCD, R_DIVM, R_DIVD} red_state_t;

	red_state_t  state_q;
	logic [63:0] u_q, v_q, g_q, n_q, rem_q, m_keep_q, d_keep_q, mag_q, den_q;
	logic [5:0]  k_q, cnt_q;
	logic        done_q;

	logic [64:0] rem_sh;
	logic        rem_ge;
	logic [63:0] rem_next, n_next;

	// One restoring division step: one quotient bit per cycle.
	always_comb begin
		rem_sh   = {rem_q, n_q[63]};
		rem_ge   = rem_sh >= {1'b0, g_q};
		rem_next = rem_ge ? 64'(rem_sh - {1'b0, g_q}) : rem_sh[63:0];
		n_next   = {n_q[62:0], rem_ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= R_IDLE;
			done_q  <= 1'b0;
			cnt_q   <= '0;
			k_q     <= '0;
		end else begin
			unique case (state_q)
				R_IDLE: begin
					// A zero magnitude is already in lowest terms as 0/1.
					done_q <= start && (mag_in == 64'd0);
					if (start) begin
						m_keep_q <= mag_in;
						d_keep_q <= den_in;
						u_q      <= mag_in;
						v_q      <= den_in;
						k_q      <= '0;
						if (mag_in == 64'd0) begin
							mag_q  <= 64'd0;
							den_q  <= 64'd1;
						end else begin
							state_q <= R_GCD;
						end
					end
				end
				R_GCD: begin
					if (u_q == v_q) begin
						g_q     <= u_q << k_q;
						n_q     <= m_keep_q;
						rem_q   <= '0;
						cnt_q   <= '0;
						state_q <= R_DIVM;
					end else if (!u_q[0] && !v_q[0]) begin
						u_q <= u_q >> 1;
						v_q <= v_q >> 1;
						k_q <= k_q + 6'd1;
					end else if (!u_q[0]) begin
						u_q <= u_q >> 1;
					end else if (!v_q[0]) begin
						v_q <= v_q >> 1;
					end else if (u_q > v_q) begin
						u_q <= u_q - v_q;
					end else begin
						v_q <= v_q - u_q;
					end
				end
				R_DIVM: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd63) begin
						mag_q   <= n_next;
						n_q     <= d_keep_q;
						rem_q   <= '0;
						state_q <= R_DIVD;
					end else begin
						n_q   <= n_next;
						rem_q <= rem_next;
					end
				end
				R_DIVD: begin
					cnt_q  <= cnt_q + 6'd1;
					done_q <= (cnt_q == 6'd63);
					if (cnt_q == 6'd63) begin
						den_q   <= n_next;
						state_q <= R_IDLE;
					end else begin
						n_q   <= n_next;
						rem_q <= rem_next;
					end
				end
				default: begin
					done_q  <= 1'b0;
					state_q <= R_IDLE;
				end
			endcase
		end
	end

	assign done    = done_q;
	assign mag_out = mag_q;
	assign den_out = den_q;

	`RAU_ASSERT_IMPLIES(a_gcd_nonzero, clk, arst_n, state_q == R_GCD, u_q != 64'd0 && v_q != 64'd0)
	`RAU_ASSERT_IMPLIES(a_div_nonzero, clk, arst_n, state_q == R_DIVM || state_q == R_DIVD, g_q != 64'd0)
	`RAU_ASSERT_IMPLIES(a_done_idle, clk, arst_n, done_q, state_q == R_IDLE && den_q != 64'd0)

endmodule
`default_nettype wire
